@@ rtl/core/amsd_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants and types for the motion / stillness detector.
// No dependencies; imported by the lane, the merge stage and the top level.
package amsd_pkg;

    // Widths fixed by the register map
    localparam int INTERVAL_W = 16;
    localparam int THR_W      = 18;
    localparam int QUIET_W    = 32;

    // Register indexes; the byte address is four times the index
    typedef enum logic [1:0] {
        REG_ENABLE   = 2'd0,
        REG_INTERVAL = 2'd1,
        REG_THRESH   = 2'd2,
        REG_QUIET    = 2'd3
    } reg_idx_t;

    // Verdict of the merge stage, handed back to the top level
    typedef struct packed {
        logic over_thr;   // summed change reached the threshold
        logic first_good; // no previous sample held yet
    } amsd_verdict_t;

endpackage

@@ rtl/core/amsd_lane.sv @@
`timescale 1ns / 1ps
// One axis lane: absolute difference of the current and the previous sample.
// Depends on amsd_pkg only for house consistency of widths.
module amsd_lane #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic signed [SAMPLE_BITS-1:0] cur,
    input  logic signed [SAMPLE_BITS-1:0] prev,
    output logic        [SAMPLE_BITS-1:0] mag
);
    import amsd_pkg::*;

    logic signed [SAMPLE_BITS:0] diff;

    // Subtract at one extra bit, then fold the sign
    always_comb begin
        diff = {cur[SAMPLE_BITS-1], cur} - {prev[SAMPLE_BITS-1], prev};
        if (diff[SAMPLE_BITS]) begin
            mag = SAMPLE_BITS'(-diff);
        end else begin
            mag = diff[SAMPLE_BITS-1:0];
        end
    end

endmodule

@@ rtl/core/amsd_merge.sv @@
`timescale 1ns / 1ps
// Merge stage: sums the three lane magnitudes and compares with the threshold.
// Depends on amsd_pkg for THR_W and amsd_verdict_t.
module amsd_merge #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic [SAMPLE_BITS-1:0]     mag_x,
    input  logic [SAMPLE_BITS-1:0]     mag_y,
    input  logic [SAMPLE_BITS-1:0]     mag_z,
    input  logic [amsd_pkg::THR_W-1:0] threshold,
    input  logic                       have_sample,
    output amsd_pkg::amsd_verdict_t    verdict
);
    import amsd_pkg::*;

    localparam int SUM_W = SAMPLE_BITS + 2;

    logic [SUM_W-1:0] sum;

    // Add the lanes and test against the threshold
    always_comb begin
        sum = SUM_W'(mag_x) + SUM_W'(mag_y) + SUM_W'(mag_z);
        verdict.over_thr   = THR_W'(sum) >= threshold;
        verdict.first_good = !have_sample;
    end

endmodule

@@ rtl/core/accel_motion_stillness_detector_top.sv @@
`timescale 1ns / 1ps
// Motion / stillness detector top level: APB registers, three axis lanes,
// merge stage, timing state and a one-word output register.
// The result word is registered: it is valid in the cycle after the input word is accepted.
// Throughput: one word per cycle while m_ready holds; the output register lets a new word in
// while the previous result is taken in the same cycle.
// Reset (aresetn low, synchronous) restores register defaults and clears state.
module accel_motion_stillness_detector_top #(
    parameter int TIME_BITS   = 32,
    parameter int SAMPLE_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input words
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [31:0]        s_now_ms,
    input  logic               s_read_ok,
    input  logic signed [15:0] s_accel_x,
    input  logic signed [15:0] s_accel_y,
    input  logic signed [15:0] s_accel_z,
    // result words
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_sample_taken,
    output logic        m_moving,
    output logic        m_still
);
    import amsd_pkg::*;

    localparam int CMP_W = (TIME_BITS > QUIET_W) ? TIME_BITS : QUIET_W;

    // configuration registers
    logic                  enable_reg;
    logic [INTERVAL_W-1:0] interval_reg;
    logic [THR_W-1:0]      thresh_reg;
    logic [QUIET_W-1:0]    quiet_reg;

    // detector state
    logic [TIME_BITS-1:0]          last_sample_reg, last_sample_next;
    logic [TIME_BITS-1:0]          last_motion_reg, last_motion_next;
    logic                          have_sample_reg, have_sample_next;
    logic signed [SAMPLE_BITS-1:0] prev_x_reg, prev_y_reg, prev_z_reg;

    // output register
    logic m_valid_reg, taken_reg, moving_reg, still_reg;

    logic                          accept, cfg_wr;
    reg_idx_t                      wr_idx;
    logic [CMP_W-1:0]              now_w;
    logic [TIME_BITS-1:0]          now_t;
    logic signed [SAMPLE_BITS-1:0] cur_x, cur_y, cur_z;
    logic [SAMPLE_BITS-1:0]        mag_x, mag_y, mag_z;
    amsd_verdict_t                 verdict;
    logic                          take, good, moving_c, motion_upd;
    logic                          quiet_old, still_c;

    // APB: always ready, write on the access phase
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign wr_idx = reg_idx_t'(paddr[3:2]);

    always_comb begin
        unique case (reg_idx_t'(paddr[3:2]))
            REG_ENABLE:   prdata = 32'(enable_reg);
            REG_INTERVAL: prdata = 32'(interval_reg);
            REG_THRESH:   prdata = 32'(thresh_reg);
            REG_QUIET:    prdata = quiet_reg;
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg   <= 1'b0;
            interval_reg <= INTERVAL_W'(8);
            thresh_reg   <= THR_W'(512);
            quiet_reg    <= QUIET_W'(60000);
        end else if (cfg_wr) begin
            unique case (wr_idx)
                REG_ENABLE:   enable_reg   <= pwdata[0];
                REG_INTERVAL: interval_reg <= pwdata[INTERVAL_W-1:0];
                REG_THRESH:   thresh_reg   <= pwdata[THR_W-1:0];
                REG_QUIET:    quiet_reg    <= pwdata[QUIET_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake: output register parts the two sides
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // trim the timestamp and the samples to the configured widths
    assign now_w = CMP_W'(s_now_ms);
    assign now_t = now_w[TIME_BITS-1:0];
    assign cur_x = s_accel_x[SAMPLE_BITS-1:0];
    assign cur_y = s_accel_y[SAMPLE_BITS-1:0];
    assign cur_z = s_accel_z[SAMPLE_BITS-1:0];

    // axis lanes
    amsd_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_x (
        .cur(cur_x), .prev(prev_x_reg), .mag(mag_x)
    );
    amsd_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_y (
        .cur(cur_y), .prev(prev_y_reg), .mag(mag_y)
    );
    amsd_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_z (
        .cur(cur_z), .prev(prev_z_reg), .mag(mag_z)
    );

    amsd_merge #(.SAMPLE_BITS(SAMPLE_BITS)) u_merge (
        .mag_x(mag_x), .mag_y(mag_y), .mag_z(mag_z),
        .threshold(thresh_reg),
        .have_sample(have_sample_reg),
        .verdict(verdict)
    );

    // decide sampling, motion and stillness for the current word
    always_comb begin
        take = enable_reg &&
               (CMP_W'(TIME_BITS'(now_t - last_sample_reg)) >= CMP_W'(interval_reg));
        good       = take && s_read_ok;
        moving_c   = good && !verdict.first_good && verdict.over_thr;
        motion_upd = good && (verdict.first_good || verdict.over_thr);

        last_sample_next = take ? now_t : last_sample_reg;
        last_motion_next = motion_upd ? now_t : last_motion_reg;
        have_sample_next = have_sample_reg || good;

        // a fresh motion stamp leaves zero elapsed time
        quiet_old = CMP_W'(TIME_BITS'(now_t - last_motion_reg)) >= CMP_W'(quiet_reg);
        still_c   = enable_reg && have_sample_next &&
                    (motion_upd ? (quiet_reg == '0) : quiet_old);
    end

    // advance detector state on each accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_sample_reg <= '0;
            last_motion_reg <= '0;
            have_sample_reg <= 1'b0;
            prev_x_reg      <= '0;
            prev_y_reg      <= '0;
            prev_z_reg      <= '0;
        end else if (accept) begin
            last_sample_reg <= last_sample_next;
            last_motion_reg <= last_motion_next;
            have_sample_reg <= have_sample_next;
            if (good) begin
                prev_x_reg <= cur_x;
                prev_y_reg <= cur_y;
                prev_z_reg <= cur_z;
            end
        end
    end

    // hold the result word until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            taken_reg  <= take;
            moving_reg <= moving_c;
            still_reg  <= still_c;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_sample_taken = taken_reg;
    assign m_moving       = moving_reg;
    assign m_still        = still_reg;

    // checks
    a_moving_needs_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && moving_reg |-> taken_reg)
        else $error("moving reported without a sample taken");

    a_accept_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid_reg)
        else $error("accepted word left no result");

    a_disabled_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !enable_reg |=> !taken_reg && !still_reg && !moving_reg)
        else $error("disabled detector reported activity");

    a_good_sets_have: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && good |=> have_sample_reg)
        else $error("good sample did not mark a held sample");

    a_still_needs_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && still_c |=> have_sample_reg)
        else $error("still reported with no sample held");

endmodule
